>>> rtl/plob_pkg.sv
// Shared types and constants for the price level order book.
package plob_pkg;

	// Default number of order slots in the table.
	localparam int unsigned TABLE_DEPTH_DEF = 64;

	// Field widths fixed by the command and result formats.
	localparam int unsigned PRICE_W = 24;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned STAMP_W = 32;

	// Command function codes; the unused code behaves as a query.
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	// Side codes.
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// Result status codes.
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// One command beat.
	typedef struct packed {
		logic [1:0]         func;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [ID_W-1:0]    ord_id;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic               status;
		logic               bid_valid;
		logic [ID_W-1:0]    bid_id;
		logic [PRICE_W-1:0] bid_price;
		logic               ask_valid;
		logic [ID_W-1:0]    ask_id;
		logic [PRICE_W-1:0] ask_price;
	} rsp_t;

	// One table slot; also used to hold the running best of each side.
	typedef struct packed {
		logic               used;
		logic               is_sell;
		logic [PRICE_W-1:0] price;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

endpackage

>>> rtl/price_level_order_book.sv
// Price level order book: slot table, scan sequencer and best bid / ask search.
//
//   Channel   Signals                 Direction  Handshake
//   command   start, busy, cmd        in         beat taken when start && !busy
//   result    done, result            out        one-cycle strobe on done
//
// Every command is one full pass: the sequencer walks the slot memory one
// slot per cycle through its single read port and one shared compare unit,
// placing, removing and ranking as it goes.
// After reset a clearing pass marks every slot free; busy stays high
// meanwhile. The result strobe cannot be held off, and busy is low again in
// the cycle in which done is high.
module price_level_order_book
	import plob_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	// Sequencer state codes.
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_REPORT = 3'd4;

	logic [2:0]         state_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      used_cnt_q;
	logic [STAMP_W-1:0] arrival_q;
	logic [STAMP_W-1:0] stamp_q;
	cmd_t               cmd_q;
	logic               place_q;
	logic               full_q;
	slot_t              bid_q;
	slot_t              ask_q;
	logic               done_q;
	rsp_t               result_q;

	// Slot memory and its registered read stage.
	slot_t              mem [TABLE_DEPTH];
	slot_t              rdata_s1;
	logic               proc_v_s1;
	logic [AW-1:0]      proc_idx_s1;

	logic               last_idx;
	logic               add_ok;
	logic               wr_en;
	logic [AW-1:0]      wr_idx;
	slot_t              wr_data;
	logic               cand_v;
	slot_t              cand;
	slot_t              best_sel;
	logic               better;
	logic               do_place;
	logic               do_remove;
	logic [STAMP_W-1:0] age_cand;
	logic [STAMP_W-1:0] age_best;

	assign last_idx = (idx_q == AW'(TABLE_DEPTH - 1));
	assign add_ok   = (cmd.func == FUNC_ADD) && (used_cnt_q != CW'(TABLE_DEPTH));
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign result   = result_q;

	// Slot stage: decide placement, removal and the candidate for ranking.
	always_comb begin
		do_place  = 1'b0;
		do_remove = 1'b0;
		cand_v    = 1'b0;
		cand      = rdata_s1;
		wr_en     = 1'b0;
		wr_idx    = proc_idx_s1;
		wr_data   = rdata_s1;
		if (state_q == ST_CLEAR) begin
			wr_en        = 1'b1;
			wr_idx       = idx_q;
			wr_data.used = 1'b0;
		end else if (proc_v_s1) begin
			if (place_q && !rdata_s1.used) begin
				do_place        = 1'b1;
				wr_en           = 1'b1;
				wr_data.used    = 1'b1;
				wr_data.is_sell = cmd_q.side;
				wr_data.price   = cmd_q.price;
				wr_data.id      = cmd_q.ord_id;
				wr_data.stamp   = stamp_q;
				cand_v          = 1'b1;
				cand            = wr_data;
			end else if (rdata_s1.used) begin
				if (cmd_q.func == FUNC_REMOVE && rdata_s1.is_sell == cmd_q.side &&
					rdata_s1.price == cmd_q.price && rdata_s1.id == cmd_q.ord_id) begin
					do_remove    = 1'b1;
					wr_en        = 1'b1;
					wr_data.used = 1'b0;
				end else begin
					cand_v = 1'b1;
				end
			end
		end
	end

	// Shared compare unit: price first, then the older arrival wins.
	always_comb begin
		best_sel = (cand.is_sell == SIDE_SELL) ? ask_q : bid_q;
		age_cand = arrival_q - cand.stamp;
		age_best = arrival_q - best_sel.stamp;
		better   = !best_sel.used
			|| ((cand.is_sell == SIDE_SELL) ? (cand.price < best_sel.price)
			                                : (cand.price > best_sel.price))
			|| ((cand.price == best_sel.price) && (age_cand > age_best));
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rdata_s1    <= mem[idx_q];
		proc_idx_s1 <= idx_q;
	end

	// Sequencer, counters and running best registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			idx_q      <= '0;
			used_cnt_q <= '0;
			arrival_q  <= '0;
			place_q    <= 1'b0;
			full_q     <= 1'b0;
			proc_v_s1  <= 1'b0;
			done_q     <= 1'b0;
			bid_q.used <= 1'b0;
			ask_q.used <= 1'b0;
		end else begin
			done_q    <= (state_q == ST_REPORT);
			proc_v_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_CLEAR: begin
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						place_q <= add_ok;
						full_q  <= (cmd.func == FUNC_ADD) && !add_ok;
						stamp_q <= arrival_q;
						if (add_ok) begin
							arrival_q  <= arrival_q + STAMP_W'(1);
							used_cnt_q <= used_cnt_q + CW'(1);
						end
						bid_q       <= '0;
						ask_q       <= '0;
						idx_q       <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					result_q.status    <= full_q ? STATUS_FULL : STATUS_DONE;
					result_q.bid_valid <= bid_q.used;
					result_q.bid_id    <= bid_q.id;
					result_q.bid_price <= bid_q.price;
					result_q.ask_valid <= ask_q.used;
					result_q.ask_id    <= ask_q.id;
					result_q.ask_price <= ask_q.price;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Slot stage updates, live in the scan and drain cycles.
			if (state_q != ST_CLEAR) begin
				if (do_place) begin
					place_q <= 1'b0;
				end
				if (do_remove) begin
					used_cnt_q <= used_cnt_q - CW'(1);
				end
				if (cand_v && better) begin
					if (cand.is_sell == SIDE_SELL) begin
						ask_q <= cand;
					end else begin
						bid_q <= cand;
					end
				end
			end
		end
	end

endmodule
